// ===== rtl/sud_pkg.sv =====
`default_nettype none

package sud_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int VAL_W        = 8;
    localparam int CMD_W        = 2;
    localparam int POS_W        = 10;
    localparam int CNT_W        = 11;
    localparam int OUT_TDATA_W  = 24;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_FIRST  = 2'd1,
        CMD_SECOND = 2'd2
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // packed from the msb down: full_res, count, position, stored
    typedef struct packed {
        logic             full_res;
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] position;
        logic             stored;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/sud_store.sv =====
`default_nettype none

module sud_store #(
    parameter int DEPTH = sud_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [sud_pkg::VAL_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [sud_pkg::VAL_W-1:0] o_rdata
);
    import sud_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/sud_ctrl.sv =====
`default_nettype none

module sud_ctrl #(
    parameter int CAPACITY = sud_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [sud_pkg::CMD_W-1:0] i_cmd,
    input  wire logic [sud_pkg::VAL_W-1:0] i_value,
    output logic                           o_ready,
    output logic                           o_res_valid,
    input  wire logic                      i_res_ready,
    output sud_pkg::t_result               o_res,
    output logic                           o_we,
    output logic      [AW-1:0]             o_waddr,
    output logic      [sud_pkg::VAL_W-1:0] o_wdata,
    output logic                           o_re,
    output logic      [AW-1:0]             o_raddr,
    input  wire logic [sud_pkg::VAL_W-1:0] i_rdata
);
    import sud_pkg::*;

    localparam int PXW = (AW > POS_W) ? AW : POS_W;
    localparam int CXW = (CW > CNT_W) ? CW : CNT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_idx, n_idx;
    logic             r_issue_done, n_issue_done;
    logic             r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]    r_cmp_idx, n_cmp_idx;
    logic [VAL_W-1:0] r_value, n_value;
    logic             r_ovalid, n_ovalid;
    t_result          r_res, n_res;

    logic             accept;
    logic             out_free;
    logic [CW-1:0]    last_idx;
    t_result          app_res;
    logic             app_ok;

    function automatic logic [POS_W-1:0] f_pos(input logic [AW-1:0] p);
        logic [PXW-1:0] w;
        w = PXW'(p);
        return w[POS_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] f_cnt(input logic [CW-1:0] c);
        logic [CXW-1:0] w;
        w = CXW'(c);
        return w[CNT_W-1:0];
    endfunction

    assign out_free = !r_ovalid || i_res_ready;
    assign o_ready  = (r_state == ST_IDLE) && out_free;
    assign accept   = i_valid && o_ready;
    assign last_idx = r_count - CW'(1);
    assign app_ok   = r_count < CAP_C;

    // result of appending at the current fill level
    always_comb begin
        app_res = '0;
        if (app_ok) begin
            app_res.stored   = 1'b1;
            app_res.position = f_pos(r_count[AW-1:0]);
            app_res.count    = f_cnt(r_count + CW'(1));
        end else begin
            app_res.full_res = 1'b1;
            app_res.count    = f_cnt(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_issue_done <= n_issue_done;
            r_cmp_vld    <= n_cmp_vld;
            r_ovalid     <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_value   <= n_value;
        r_res     <= n_res;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_idx;
        n_value      = r_value;
        n_ovalid     = r_ovalid && !i_res_ready;
        n_res        = r_res;
        o_we         = 1'b0;
        o_waddr      = r_count[AW-1:0];
        o_wdata      = (r_state == ST_IDLE) ? i_value : r_value;
        o_re         = 1'b0;
        o_raddr      = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_value = i_value;
                    case (i_cmd)
                        CMD_CLEAR: begin
                            n_count  = '0;
                            n_res    = '0;
                            n_ovalid = 1'b1;
                        end
                        CMD_FIRST: begin
                            o_we     = app_ok;
                            n_count  = app_ok ? r_count + CW'(1) : r_count;
                            n_res    = app_res;
                            n_ovalid = 1'b1;
                        end
                        CMD_SECOND: begin
                            if (r_count == '0) begin
                                o_we     = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_res    = app_res;
                                n_ovalid = 1'b1;
                            end else begin
                                n_idx        = '0;
                                n_issue_done = 1'b0;
                                n_state      = ST_SCAN;
                            end
                        end
                        default: begin
                            n_res       = '0;
                            n_res.count = f_cnt(r_count);
                            n_ovalid    = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // read one entry per cycle, compare it the cycle after
                o_re      = !r_issue_done;
                n_cmp_vld = !r_issue_done;
                if (!r_issue_done) begin
                    if (CW'(r_idx) == last_idx) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
                if (r_cmp_vld) begin
                    if (i_rdata == r_value) begin
                        n_res          = '0;
                        n_res.position = f_pos(r_cmp_idx);
                        n_res.count    = f_cnt(r_count);
                        n_ovalid       = 1'b1;
                        n_cmp_vld      = 1'b0;
                        n_state        = ST_IDLE;
                    end else if (CW'(r_cmp_idx) == last_idx) begin
                        o_we      = app_ok;
                        n_count   = app_ok ? r_count + CW'(1) : r_count;
                        n_res     = app_res;
                        n_ovalid  = 1'b1;
                        n_cmp_vld = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== rtl/set_union_dedup_unit.sv =====
// Union store of up to CAPACITY bytes. Each transaction carries a command in tuser
// (clear, first-list append, second-list append if absent) and a byte in tdata, and
// gives exactly one result. Clear, first-list appends, second-list appends into an
// empty store and unused commands produce their result in the cycle after acceptance.
// A second-list byte walks the stored entries through the single read port of the
// store, one entry per cycle, stopping at the first match: its result is registered
// once a match is found or the last stored entry has been compared. The block takes
// one item at a time; it accepts the next one once the current result has been
// produced and the output register is empty or being drained. Store contents are
// not cleared after reset; only entries below the fill count are ever read.
`default_nettype none

module set_union_dedup_unit #(
    parameter int CAPACITY = sud_pkg::CAPACITY_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [sud_pkg::VAL_W-1:0]       i_s_tdata,  // [7:0] value
    input  wire logic [sud_pkg::CMD_W-1:0]       i_s_tuser,  // [1:0] command
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [0] stored, [10:1] position, [21:11] count, [22] full_res, [23] zero
    output logic      [sud_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import sud_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic             we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [AW-1:0]    raddr;
    logic [VAL_W-1:0] rdata;
    t_result          res;

    sud_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_cmd       (i_s_tuser),
        .i_value     (i_s_tdata),
        .o_ready     (o_s_tready),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    sud_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_m_tdata = {1'b0, res};

endmodule

`default_nettype wire

// ===== rtl/sud_chk.sv =====
`default_nettype none

module sud_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata
);

    // hold a stalled result transaction
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_stored_not_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[22]))
        else $error("result both stored and dropped");

    // an append lands at the old fill level
    a_stored_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> o_m_tdata[20:11] == 10'(o_m_tdata[10:1] + 10'd1))
        else $error("count does not follow appended position");

    a_full_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[22] |-> o_m_tdata[10:1] == 10'd0)
        else $error("dropped byte reports a position");

    // never take a new item while a result waits on a stalled sink
    a_no_accept_blocked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && o_m_tvalid |-> i_m_tready)
        else $error("accepting while output is blocked");

endmodule

bind set_union_dedup_unit sud_chk u_sud_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
